// ----- rtl/ansi_escape_key_decoder_unit_macros.svh -----
// ----------------------------------------------------------------------------
// ANSI escape key decoder assertion macros
// Concurrent assertion shorthands used by the checker file aekd_checker.
// ----------------------------------------------------------------------------
`ifndef ANSI_ESCAPE_KEY_DECODER_UNIT_MACROS_SVH
`define ANSI_ESCAPE_KEY_DECODER_UNIT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define AEKD_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("aekd assertion failed");

// next-cycle implication, disabled while reset is asserted
`define AEKD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("aekd assertion failed");

// next-cycle implication that also holds across reset
`define AEKD_ASSERT_ALWAYS_NEXT(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("aekd assertion failed");

`endif

// ----- rtl/aekd_pkg.sv -----
// ----------------------------------------------------------------------------
// aekd_pkg
// Event codes, byte constants, phase codes, shared types and the plain byte classifier of the decoder.
// ----------------------------------------------------------------------------
package aekd_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned KIND_W  = 4;
    localparam int unsigned CHAR_W  = 7;
    localparam int unsigned PHASE_W = 2;
    localparam int unsigned NUM_W   = 8;

    localparam logic [KIND_W-1:0] EV_NONE      = 4'd0;
    localparam logic [KIND_W-1:0] EV_CHAR      = 4'd1;
    localparam logic [KIND_W-1:0] EV_ENTER     = 4'd2;
    localparam logic [KIND_W-1:0] EV_BACKSPACE = 4'd3;
    localparam logic [KIND_W-1:0] EV_TAB       = 4'd4;
    localparam logic [KIND_W-1:0] EV_UP        = 4'd5;
    localparam logic [KIND_W-1:0] EV_DOWN      = 4'd6;
    localparam logic [KIND_W-1:0] EV_RIGHT     = 4'd7;
    localparam logic [KIND_W-1:0] EV_LEFT      = 4'd8;
    localparam logic [KIND_W-1:0] EV_HOME      = 4'd9;
    localparam logic [KIND_W-1:0] EV_END       = 4'd10;
    localparam logic [KIND_W-1:0] EV_DELETE    = 4'd11;
    localparam logic [KIND_W-1:0] EV_PGUP      = 4'd12;
    localparam logic [KIND_W-1:0] EV_PGDN      = 4'd13;

    localparam logic [PHASE_W-1:0] PH_NORMAL = 2'd0;
    localparam logic [PHASE_W-1:0] PH_ESC    = 2'd1;
    localparam logic [PHASE_W-1:0] PH_CSI    = 2'd2;
    localparam logic [PHASE_W-1:0] PH_DIGITS = 2'd3;

    localparam logic [BYTE_W-1:0] B_BS    = 8'h08;
    localparam logic [BYTE_W-1:0] B_TAB   = 8'h09;
    localparam logic [BYTE_W-1:0] B_LF    = 8'h0A;
    localparam logic [BYTE_W-1:0] B_CR    = 8'h0D;
    localparam logic [BYTE_W-1:0] B_ESC   = 8'd27;
    localparam logic [BYTE_W-1:0] B_DEL   = 8'h7F;
    localparam logic [BYTE_W-1:0] B_SPACE = 8'd32;
    localparam logic [BYTE_W-1:0] B_TILDE = 8'd126;
    localparam logic [BYTE_W-1:0] B_CTRL_HI = 8'd26;
    localparam logic [BYTE_W-1:0] B_LBRACK = 8'h5B;
    localparam logic [BYTE_W-1:0] B_SS3   = 8'h4F;
    localparam logic [BYTE_W-1:0] B_ZERO  = 8'h30;
    localparam logic [BYTE_W-1:0] B_NINE  = 8'h39;
    localparam logic [BYTE_W-1:0] B_UP    = 8'h41;
    localparam logic [BYTE_W-1:0] B_DOWN  = 8'h42;
    localparam logic [BYTE_W-1:0] B_RIGHT = 8'h43;
    localparam logic [BYTE_W-1:0] B_LEFT  = 8'h44;
    localparam logic [BYTE_W-1:0] B_END   = 8'h46;
    localparam logic [BYTE_W-1:0] B_HOME  = 8'h48;

    localparam logic [NUM_W-1:0] NUM_MAX    = 8'd255;
    localparam logic [NUM_W-1:0] NUM_DELETE = 8'd3;
    localparam logic [NUM_W-1:0] NUM_PGUP   = 8'd5;
    localparam logic [NUM_W-1:0] NUM_PGDN   = 8'd6;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [CHAR_W-1:0] ch;
    } aekd_event_t;

    typedef struct packed {
        logic valid;
        logic advance;
    } aekd_ctrl_t;

    function automatic aekd_event_t classify_plain(input logic [BYTE_W-1:0] b);
        aekd_event_t ev;
        ev.kind = EV_NONE;
        ev.ch   = '0;
        if (b == B_DEL || b == B_BS) begin
            ev.kind = EV_BACKSPACE;
        end else if (b == B_TAB) begin
            ev.kind = EV_TAB;
        end else if (b == B_LF) begin
            ev.kind = EV_ENTER;
        end else if ((b >= B_SPACE && b <= B_TILDE) || (b != '0 && b <= B_CTRL_HI)) begin
            ev.kind = EV_CHAR;
            ev.ch   = b[CHAR_W-1:0];
        end
        return ev;
    endfunction

endpackage

// ----- rtl/ansi_escape_key_decoder_unit.sv -----
// ----------------------------------------------------------------------------
// ansi_escape_key_decoder_unit
// Terminal byte to key event decoder with ANSI/VT100 escape handling.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake           Payload
//  s_        in         s_valid / s_ready   s_rx_byte[7:0]
//  m_        out        m_valid / m_ready   m_event_kind[3:0], m_char_code[6:0]
//
//  One item per cycle sustained while m_ready is high; an accepted item is
//  decoded from the input register and registered onto m_valid and the payload.
//  Reset clears the escape phase, the number and both valid flags.
//  A stalled result holds the result register; the input register drains into
//  it the same cycle the result is taken, so a stall costs no bubbles.
// ----------------------------------------------------------------------------
module ansi_escape_key_decoder_unit
    import aekd_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [BYTE_W-1:0] s_rx_byte,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [KIND_W-1:0] m_event_kind,
    output logic [CHAR_W-1:0] m_char_code
);

    logic              in_valid;
    logic [BYTE_W-1:0] in_byte;
    logic              out_free;
    aekd_ctrl_t        ctrl;
    aekd_event_t       ev;
    logic              m_valid_reg;
    logic              m_valid_next;
    aekd_event_t       result_reg;
    aekd_event_t       result_next;

    assign out_free     = !m_valid_reg || m_ready;
    assign ctrl.valid   = in_valid;
    assign ctrl.advance = in_valid && out_free;

    aekd_in_reg u_in_reg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_rx_byte (s_rx_byte),
        .advance   (ctrl.advance),
        .in_valid  (in_valid),
        .in_byte   (in_byte)
    );

    aekd_decode u_decode (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (ctrl),
        .in_byte (in_byte),
        .ev      (ev)
    );

    always_comb begin
        m_valid_next = m_valid_reg;
        result_next  = result_reg;
        if (ctrl.advance) begin
            m_valid_next = 1'b1;
            result_next  = ev;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
        result_reg <= result_next;
    end

    assign m_valid      = m_valid_reg;
    assign m_event_kind = result_reg.kind;
    assign m_char_code  = result_reg.ch;

endmodule

// ----- rtl/aekd_in_reg.sv -----
// ----------------------------------------------------------------------------
// aekd_in_reg
// Input register: captures one received byte and holds it until decoded.
// ----------------------------------------------------------------------------
module aekd_in_reg
    import aekd_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [BYTE_W-1:0] s_rx_byte,
    input  logic              advance,
    output logic              in_valid,
    output logic [BYTE_W-1:0] in_byte
);

    logic              valid_reg;
    logic              valid_next;
    logic [BYTE_W-1:0] byte_reg;
    logic [BYTE_W-1:0] byte_next;
    logic              take;

    assign s_ready = !valid_reg || advance;
    assign take    = s_valid && s_ready;

    always_comb begin
        valid_next = valid_reg;
        byte_next  = byte_reg;
        if (take) begin
            valid_next = 1'b1;
            byte_next  = s_rx_byte;
        end else if (advance) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        byte_reg <= byte_next;
    end

    assign in_valid = valid_reg;
    assign in_byte  = byte_reg;

endmodule

// ----- rtl/aekd_decode.sv -----
// ----------------------------------------------------------------------------
// aekd_decode
// Escape phase tracker and key classifier; state moves when an item advances.
// ----------------------------------------------------------------------------
module aekd_decode
    import aekd_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  aekd_ctrl_t        ctrl,
    input  logic [BYTE_W-1:0] in_byte,
    output aekd_event_t       ev
);

    logic [PHASE_W-1:0] phase_reg;
    logic [PHASE_W-1:0] phase_next;
    logic [NUM_W-1:0]   num_reg;
    logic [NUM_W-1:0]   num_next;
    logic               is_digit;
    logic [3:0]         digit;
    logic [11:0]        num_acc;
    aekd_event_t        ev_c;

    assign is_digit = (in_byte >= B_ZERO) && (in_byte <= B_NINE);
    assign digit    = in_byte[3:0];
    assign num_acc  = {1'b0, num_reg, 3'b000} + {3'b000, num_reg, 1'b0} + {8'd0, digit};

    always_comb begin
        phase_next = phase_reg;
        num_next   = num_reg;
        ev_c.kind  = EV_NONE;
        ev_c.ch    = '0;
        if (in_byte == B_CR) begin
            phase_next = PH_NORMAL;
            num_next   = '0;
            ev_c.kind  = EV_ENTER;
        end else begin
            unique case (phase_reg)
                PH_ESC: begin
                    if (in_byte == B_LBRACK || in_byte == B_SS3) begin
                        phase_next = PH_CSI;
                    end else begin
                        phase_next = PH_NORMAL;
                        num_next   = '0;
                        ev_c       = classify_plain(in_byte);
                    end
                end
                PH_CSI: begin
                    if (is_digit) begin
                        num_next   = {4'd0, digit};
                        phase_next = PH_DIGITS;
                    end else begin
                        phase_next = PH_NORMAL;
                        num_next   = '0;
                        priority if (in_byte == B_UP) begin
                            ev_c.kind = EV_UP;
                        end else if (in_byte == B_DOWN) begin
                            ev_c.kind = EV_DOWN;
                        end else if (in_byte == B_RIGHT) begin
                            ev_c.kind = EV_RIGHT;
                        end else if (in_byte == B_LEFT) begin
                            ev_c.kind = EV_LEFT;
                        end else if (in_byte == B_HOME) begin
                            ev_c.kind = EV_HOME;
                        end else if (in_byte == B_END) begin
                            ev_c.kind = EV_END;
                        end else begin
                            ev_c = classify_plain(in_byte);
                        end
                    end
                end
                PH_DIGITS: begin
                    if (is_digit) begin
                        // saturate at the top of the number range
                        num_next = (num_acc > {4'd0, NUM_MAX}) ? NUM_MAX : num_acc[NUM_W-1:0];
                    end else if (in_byte == B_TILDE) begin
                        phase_next = PH_NORMAL;
                        num_next   = '0;
                        priority if (num_reg == NUM_DELETE) begin
                            ev_c.kind = EV_DELETE;
                        end else if (num_reg == NUM_PGUP) begin
                            ev_c.kind = EV_PGUP;
                        end else if (num_reg == NUM_PGDN) begin
                            ev_c.kind = EV_PGDN;
                        end else begin
                            ev_c.kind = EV_NONE;
                        end
                    end else begin
                        phase_next = PH_NORMAL;
                        num_next   = '0;
                        ev_c       = classify_plain(in_byte);
                    end
                end
                default: begin
                    if (in_byte == B_ESC) begin
                        phase_next = PH_ESC;
                    end else begin
                        ev_c = classify_plain(in_byte);
                    end
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_NORMAL;
            num_reg   <= '0;
        end else if (ctrl.valid && ctrl.advance) begin
            phase_reg <= phase_next;
            num_reg   <= num_next;
        end
    end

    assign ev = ev_c;

endmodule

// ----- rtl/aekd_checker.sv -----
// ----------------------------------------------------------------------------
// aekd_checker
// Port-level checks of the key decoder, bound to the top level.
// ----------------------------------------------------------------------------
`include "ansi_escape_key_decoder_unit_macros.svh"

module aekd_checker
    import aekd_pkg::*;
(
    input logic              aclk,
    input logic              aresetn,
    input logic              s_valid,
    input logic              s_ready,
    input logic [BYTE_W-1:0] s_rx_byte,
    input logic              m_valid,
    input logic              m_ready,
    input logic [KIND_W-1:0] m_event_kind,
    input logic [CHAR_W-1:0] m_char_code
);

    logic                     in_wait;
    logic                     out_stall;
    logic [KIND_W+CHAR_W-1:0] out_word;
    logic                     is_char;
    logic                     char_ok;

    assign in_wait   = s_valid && !s_ready;
    assign out_stall = m_valid && !m_ready;
    assign out_word  = {m_event_kind, m_char_code};
    assign is_char   = m_valid && (m_event_kind == EV_CHAR);
    assign char_ok   = (m_char_code != '0) && (m_char_code != B_DEL[CHAR_W-1:0]);

    `AEKD_ASSERT_NEXT(a_in_hold, aclk, aresetn, in_wait, s_valid && $stable(s_rx_byte))
    `AEKD_ASSERT_NEXT(a_out_hold, aclk, aresetn, out_stall, m_valid && $stable(out_word))
    `AEKD_ASSERT_SAME(a_char_zero, aclk, aresetn, m_valid && !is_char, m_char_code == '0)
    `AEKD_ASSERT_SAME(a_char_legal, aclk, aresetn, is_char, char_ok)
    `AEKD_ASSERT_ALWAYS_NEXT(a_reset_idle, aclk, !aresetn, !m_valid)

endmodule

bind ansi_escape_key_decoder_unit aekd_checker u_aekd_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .s_valid      (s_valid),
    .s_ready      (s_ready),
    .s_rx_byte    (s_rx_byte),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_event_kind (m_event_kind),
    .m_char_code  (m_char_code)
);
